### rtl/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg: shared types and constants
// Power mode codes, register indexes, reset values and the structs that pass
// between the supervisor modules.
// ----------------------------------------------------------------------------
package bhs_pkg;

  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [1:0] {
    MODE_ON      = 2'd0,
    MODE_OFF     = 2'd1,
    MODE_WAITING = 2'd2
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOW_THRESHOLD  = 8'd0,
    REG_HIGH_THRESHOLD = 8'd1,
    REG_DEAD_TICKS     = 8'd2,
    REG_RECOVERY_TICKS = 8'd3
  } reg_index_t;

  localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RESET  = 10'd750;
  localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RESET = 10'd800;
  localparam logic [COUNT_W-1:0] DEAD_TICKS_RESET     = 8'd75;
  localparam logic [COUNT_W-1:0] RECOVERY_TICKS_RESET = 8'd76;

  typedef struct packed {
    logic [LEVEL_W-1:0] low_threshold;
    logic [LEVEL_W-1:0] high_threshold;
    logic [COUNT_W-1:0] dead_ticks;
    logic [COUNT_W-1:0] recovery_ticks;
  } cfg_t;

  typedef struct packed {
    logic               heartbeat_level;
    logic [LEVEL_W-1:0] battery_level;
    logic               tick;
  } item_t;

  typedef struct packed {
    logic  hang_reset_pulse;
    logic  power_reset_pulse;
    mode_t power_mode;
  } result_t;

endpackage

### rtl/bhs_cfg.sv
// ----------------------------------------------------------------------------
// bhs_cfg: configuration register file
// Holds thresholds and tick limits; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bhs_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [bhs_pkg::CFG_ADDR_W-1:0] wr_addr,
  input  logic [bhs_pkg::CFG_DATA_W-1:0] wr_data,
  output bhs_pkg::cfg_t                  cfg
);
  import bhs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold  <= LOW_THRESHOLD_RESET;
      cfg.high_threshold <= HIGH_THRESHOLD_RESET;
      cfg.dead_ticks     <= DEAD_TICKS_RESET;
      cfg.recovery_ticks <= RECOVERY_TICKS_RESET;
    end else if (wr_en) begin
      unique case (wr_addr)
        REG_LOW_THRESHOLD:  cfg.low_threshold  <= wr_data;
        REG_HIGH_THRESHOLD: cfg.high_threshold <= wr_data;
        REG_DEAD_TICKS:     cfg.dead_ticks     <= wr_data[COUNT_W-1:0];
        REG_RECOVERY_TICKS: cfg.recovery_ticks <= wr_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/bhs_core.sv
// ----------------------------------------------------------------------------
// bhs_core: supervisor state and per-tick rules
// Battery hysteresis state machine followed by the heartbeat miss counter;
// state advances on each fired item.
// ----------------------------------------------------------------------------
module bhs_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  bhs_pkg::item_t   item,
  input  bhs_pkg::cfg_t    cfg,
  output bhs_pkg::result_t result
);
  import bhs_pkg::*;

  mode_t              mode;
  mode_t              mode_next;
  logic [COUNT_W-1:0] recovery_counter;
  logic [COUNT_W-1:0] recovery_counter_next;
  logic [COUNT_W-1:0] miss_counter;
  logic [COUNT_W-1:0] miss_counter_next;
  logic               previous_heartbeat;
  logic               previous_heartbeat_next;
  logic [COUNT_W-1:0] recovery_inc;
  logic [COUNT_W-1:0] miss_inc;
  logic               below_low;
  logic               above_high;
  logic               recovered;
  logic               power_pulse;
  logic               hang_pulse;

  assign below_low    = item.battery_level < cfg.low_threshold;
  assign above_high   = item.battery_level > cfg.high_threshold;
  assign recovery_inc = recovery_counter + COUNT_W'(1);
  assign recovered    = recovery_inc >= cfg.recovery_ticks;
  assign miss_inc     = miss_counter + COUNT_W'(1);

  // battery rule: next state
  always_comb begin
    mode_next             = mode;
    recovery_counter_next = recovery_counter;
    if (item.tick) begin
      unique case (mode)
        MODE_ON: begin
          if (below_low) begin
            mode_next             = MODE_OFF;
            recovery_counter_next = '0;
          end
        end
        MODE_WAITING: begin
          if (below_low) begin
            mode_next = MODE_OFF;
          end else begin
            recovery_counter_next = recovery_inc;
            if (recovered) mode_next = MODE_ON;
          end
        end
        default: begin
          // off, and the unused code which behaves as off
          mode_next = MODE_OFF;
          if (above_high) begin
            mode_next             = MODE_WAITING;
            recovery_counter_next = '0;
          end
        end
      endcase
    end
  end

  // battery rule: pulse output
  always_comb begin
    power_pulse = 1'b0;
    if (item.tick) begin
      unique case (mode)
        MODE_ON:      power_pulse = below_low;
        MODE_WAITING: power_pulse = !below_low && recovered;
        default:      power_pulse = 1'b0;
      endcase
    end
  end

  // heartbeat rule, sees the updated mode
  always_comb begin
    miss_counter_next       = miss_counter;
    previous_heartbeat_next = previous_heartbeat;
    hang_pulse              = 1'b0;
    if (item.tick) begin
      if (item.heartbeat_level != previous_heartbeat) begin
        miss_counter_next       = '0;
        previous_heartbeat_next = item.heartbeat_level;
      end else if (miss_inc >= cfg.dead_ticks && mode_next == MODE_ON) begin
        hang_pulse        = 1'b1;
        miss_counter_next = '0;
      end else begin
        miss_counter_next = miss_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_ON;
      recovery_counter   <= '0;
      miss_counter       <= '0;
      previous_heartbeat <= 1'b1;
    end else if (fire) begin
      mode               <= mode_next;
      recovery_counter   <= recovery_counter_next;
      miss_counter       <= miss_counter_next;
      previous_heartbeat <= previous_heartbeat_next;
    end
  end

  assign result.power_mode        = mode_next;
  assign result.power_reset_pulse = power_pulse;
  assign result.hang_reset_pulse  = hang_pulse;

endmodule

### rtl/battery_and_heartbeat_supervisor_top.sv
// ----------------------------------------------------------------------------
// battery_and_heartbeat_supervisor_top: battery supervisor with heartbeat watchdog
// Input register, one pass of compare and count logic, result register.
// ----------------------------------------------------------------------------
// usage
//   s_* stream: one transaction per supervision period (tick, battery
//     sample, heartbeat level); tick low reports the mode and changes nothing
//   m_* stream: exactly one result transaction per input transaction, in order
//     (power mode after the period, power reset pulse, hang reset pulse)
//   cfg_* channel: register writes, always ready; index 0 low threshold,
//     1 high threshold, 2 dead ticks, 3 recovery ticks, other indexes dropped;
//     write only while no transaction is in flight
// timing
//   the result is valid 1 cycle after input accept when the result register
//   is free (core logic sits between input register and result register);
//   throughput is one transaction per cycle, set by the single-cycle state
//   update in the core
// reset
//   synchronous rst empties both pipeline registers, restores register
//   defaults (750, 800, 75, 76), mode on, counters zero, last heartbeat high
// backpressure
//   while m_tready is low the result register holds and one more input
//   transaction is taken into the input register; then s_tready drops
// ----------------------------------------------------------------------------
module battery_and_heartbeat_supervisor_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [0] tick, [10:1] battery_level, [11] heartbeat_level, [15:12] zero
  input  logic [15:0]                    s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] power_mode, [2] power_reset_pulse, [3] hang_reset_pulse, [7:4] zero
  output logic [7:0]                     m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bhs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bhs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bhs_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    fire;
  result_t step_result;
  result_t out_result;

  // config writes never stall
  assign cfg_ready = 1'b1;

  bhs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // the held item moves on when the result register is free or being drained
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[$bits(item_t)-1:0];
    end
  end

  // state registers and rule logic
  bhs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {{(8 - $bits(result_t)){1'b0}}, out_result};

  // a hang pulse only fires with the mode on
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[1:0] == MODE_ON)
    else $error("hang pulse outside on mode");

  // a power pulse marks entry to off or on, never waiting
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] != MODE_WAITING)
    else $error("power pulse with waiting mode");

  // the unused mode code never reaches the output
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("invalid mode code");

  // input stalls only behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

endmodule

### dv/bhs_supervision_checker.sv
// ----------------------------------------------------------------------------
// bhs_supervision_checker: result checker for the battery and heartbeat supervisor
// Watches the input, result and register channels, predicts the power mode
// and both reset pulses for every accepted input transaction, and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module bhs_supervision_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [15:0]                    s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [7:0]                     m_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bhs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bhs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending
);
  import bhs_pkg::*;

  // shadow registers and supervisor state
  logic [LEVEL_W-1:0] low_thr;
  logic [LEVEL_W-1:0] high_thr;
  logic [COUNT_W-1:0] dead_lim;
  logic [COUNT_W-1:0] recovery_lim;
  mode_t              mode;
  logic [COUNT_W-1:0] recovery_cnt;
  logic [COUNT_W-1:0] miss_cnt;
  logic               last_beat;

  result_t expected_results[$];
  int      err_count = 0;

  // one supervision period: battery rule first, then the heartbeat rule
  function automatic result_t next_period(item_t it);
    result_t r;
    logic    power_pulse;
    logic    hang_pulse;
    power_pulse = 1'b0;
    hang_pulse  = 1'b0;
    if (it.tick) begin
      case (mode)
        MODE_ON: begin
          if (it.battery_level < low_thr) begin
            mode         = MODE_OFF;
            power_pulse  = 1'b1;
            recovery_cnt = '0;
          end
        end
        MODE_WAITING: begin
          if (it.battery_level < low_thr) begin
            mode = MODE_OFF;
          end else begin
            recovery_cnt = recovery_cnt + 1'b1;
            if (recovery_cnt >= recovery_lim) begin
              mode        = MODE_ON;
              power_pulse = 1'b1;
            end
          end
        end
        default: begin
          mode = MODE_OFF;
          if (it.battery_level > high_thr) begin
            mode         = MODE_WAITING;
            recovery_cnt = '0;
          end
        end
      endcase
      if (it.heartbeat_level != last_beat) begin
        miss_cnt  = '0;
        last_beat = it.heartbeat_level;
      end else begin
        miss_cnt = miss_cnt + 1'b1;
        if (miss_cnt >= dead_lim && mode == MODE_ON) begin
          hang_pulse = 1'b1;
          miss_cnt   = '0;
        end
      end
    end
    r.power_mode        = mode;
    r.power_reset_pulse = power_pulse;
    r.hang_reset_pulse  = hang_pulse;
    return r;
  endfunction

  task automatic report_field(input string field, input int want, input int got);
    err_count++;
    if (err_count <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      low_thr      = LOW_THRESHOLD_RESET;
      high_thr     = HIGH_THRESHOLD_RESET;
      dead_lim     = DEAD_TICKS_RESET;
      recovery_lim = RECOVERY_TICKS_RESET;
      mode         = MODE_ON;
      recovery_cnt = '0;
      miss_cnt     = '0;
      last_beat    = 1'b1;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_LOW_THRESHOLD:  low_thr      = cfg_data;
          REG_HIGH_THRESHOLD: high_thr     = cfg_data;
          REG_DEAD_TICKS:     dead_lim     = cfg_data[COUNT_W-1:0];
          REG_RECOVERY_TICKS: recovery_lim = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen = result_t'(m_tdata[3:0]);
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result with nothing expected, got 0x%0h", $realtime, m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (seen.power_mode !== want.power_mode)
            report_field("power_mode", want.power_mode, seen.power_mode);
          if (seen.power_reset_pulse !== want.power_reset_pulse)
            report_field("power_reset_pulse", want.power_reset_pulse, seen.power_reset_pulse);
          if (seen.hang_reset_pulse !== want.hang_reset_pulse)
            report_field("hang_reset_pulse", want.hang_reset_pulse, seen.hang_reset_pulse);
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(next_period(item_t'(s_tdata[11:0])));
    end
    pending    <= expected_results.size();
    mismatches <= err_count;
  end

endmodule

### dv/battery_and_heartbeat_supervisor_top_test.sv
// ----------------------------------------------------------------------------
// battery_and_heartbeat_supervisor_top_test: supervisor testbench top
// Drives directed and random supervision periods under several register
// settings, with random gaps on both streams and two long result stalls;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module battery_and_heartbeat_supervisor_top_test;
  import bhs_pkg::*;

  localparam int PHASES         = 8;
  localparam int PERIODS_EACH   = 180;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  // [0] tick, [10:1] battery_level, [11] heartbeat_level, [15:12] zero
  logic [15:0]           s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // [1:0] power_mode, [2] power_reset_pulse, [3] hang_reset_pulse, [7:4] zero
  logic [7:0]            m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int pending;
  int quiet_cycles = 0;

  // stimulus-side copy of the settings, only used to aim the random samples
  int cfg_low  = LOW_THRESHOLD_RESET;
  int cfg_high = HIGH_THRESHOLD_RESET;
  int cfg_dead = DEAD_TICKS_RESET;

  // heartbeat runs: a stretch of steady or toggling levels
  int   beat_run    = 0;
  bit   beat_steady = 1'b0;
  logic beat_level  = 1'b1;

  // sender gap-free stretch
  int send_calm = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  battery_and_heartbeat_supervisor_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  bhs_supervision_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic item_t period(input bit tick, input int level, input bit beat);
    item_t it;
    it.tick            = tick;
    it.battery_level   = level[LEVEL_W-1:0];
    it.heartbeat_level = beat;
    return it;
  endfunction

  // random period aimed around the current thresholds; mostly samples that
  // keep the mode moving toward on so the recovery and miss counts run long
  function automatic item_t random_period();
    item_t it;
    int    pick;
    pick    = $urandom_range(0, 99);
    it.tick = ($urandom_range(0, 99) < 92);
    if (pick < 6)
      it.battery_level = (cfg_low == 0) ? '0 : LEVEL_W'($urandom_range(0, cfg_low - 1));
    else if (pick < 10)
      it.battery_level = pick[0] ? 10'd1023 : 10'd0;
    else if (pick < 20)
      it.battery_level = LEVEL_W'($urandom_range(0, 1023));
    else if (pick < 30)
      it.battery_level = pick[0] ? LEVEL_W'(cfg_low) : LEVEL_W'(cfg_high);
    else
      it.battery_level = (cfg_high >= 1023) ? 10'd1023 :
                         LEVEL_W'($urandom_range(cfg_high + 1, 1023));
    if (beat_run == 0) begin
      beat_run    = $urandom_range(1, cfg_dead + 20);
      beat_steady = ($urandom_range(0, 1) != 0);
    end
    beat_run--;
    if (!beat_steady)
      beat_level = ~beat_level;
    it.heartbeat_level = beat_level;
    return it;
  endfunction

  // one input transaction after a random gap; valid stays high between
  // back-to-back transactions
  task automatic send_item(input item_t it);
    int gap;
    if (send_calm > 0) begin
      gap = 0;
      send_calm--;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 24) == 0)
        send_calm = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, it};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and let every outstanding result come back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input int data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register set plus one write to an unused index, which must be dropped
  task automatic set_supervisor(input int lo, input int hi, input int dead, input int rec);
    cfg_write(CFG_ADDR_W'($urandom_range(4, 255)), $urandom_range(0, 1023));
    cfg_write(REG_LOW_THRESHOLD, lo);
    cfg_write(REG_HIGH_THRESHOLD, hi);
    cfg_write(REG_DEAD_TICKS, dead);
    cfg_write(REG_RECOVERY_TICKS, rec);
    cfg_valid <= 1'b0;
    cfg_low  = lo & 10'h3FF;
    cfg_high = hi & 10'h3FF;
    cfg_dead = dead & 8'hFF;
  endtask

  // result side: random stalls, gap-free stretches, and two long hold-offs
  // that back the block up into its input
  initial begin : result_sink
    int gap;
    int calm;
    int taken;
    calm  = 0;
    taken = 0;
    forever begin
      if (calm > 0) begin
        gap = 0;
        calm--;
      end else begin
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 19) == 0)
          calm = $urandom_range(10, 40);
      end
      if (taken == 400 || taken == 1000)
        gap = 150;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int lo;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: idle periods, hysteresis edges, abort from waiting
    send_item(period(0, 0, 0));
    send_item(period(0, 1023, 1));
    send_item(period(1, 1023, 0));
    send_item(period(1, 750, 1));
    send_item(period(1, 749, 1));
    send_item(period(1, 800, 0));
    send_item(period(1, 801, 1));
    send_item(period(1, 749, 0));
    send_item(period(1, 1023, 1));
    settle();

    // shortest counts: recovery and hang in the same period
    set_supervisor(750, 800, 1, 1);
    send_item(period(1, 750, 1));
    send_item(period(1, 1023, 0));
    send_item(period(1, 1023, 0));
    send_item(period(0, 512, 0));
    settle();

    // zero counts fire on the first qualifying period
    set_supervisor(500, 510, 0, 0);
    send_item(period(1, 0, 1));
    send_item(period(1, 511, 1));
    send_item(period(1, 500, 1));
    send_item(period(1, 1023, 0));
    send_item(period(1, 1023, 0));
    settle();

    // crossed thresholds
    set_supervisor(1023, 0, 4, 3);
    send_item(period(1, 1022, 0));
    send_item(period(1, 1, 1));
    send_item(period(1, 1022, 1));
    send_item(period(1, 1023, 0));
    send_item(period(1, 1023, 1));
    settle();

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_supervisor(0, 1023, 255, 255);
        1: set_supervisor(1023, 0, 1, 1);
        2: set_supervisor(0, 0, 255, 1);
        7: set_supervisor($urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), $urandom_range(0, 1023));
        default: begin
          lo = $urandom_range(0, 1000);
          set_supervisor(lo, lo + $urandom_range(0, 23), $urandom_range(1, 30),
                         $urandom_range(1, 30));
        end
      endcase
      for (int n = 0; n < PERIODS_EACH; n++)
        send_item(random_period());
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
